// File: sv/fp32a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32a_pkg
// Shared constants and types for the binary32 adder.
// ----------------------------------------------------------------------------
package fp32a_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned MantW = 27;

  localparam logic [WordW-1:0] QnanBits = 32'h7FC0_0000;
  localparam logic [ExpW-1:0]  ExpMax   = 8'hFF;

  typedef struct packed {
    logic             sign;
    logic [ExpW-1:0]  exp;
    logic [FracW-1:0] frac;
  } fp32_t;

  typedef struct packed {
    logic            special;
    logic [WordW-1:0] special_bits;
    logic            sign;
    logic            zero_sign;
    logic [ExpW:0]   exp;
    logic [MantW:0]  mant;
  } align_t;

endpackage

// File: sv/fp32a_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32a_align
// Special-case decode, magnitude ordering, alignment and add/subtract.
// ----------------------------------------------------------------------------
module fp32a_align (
  input  logic [fp32a_pkg::WordW-1:0] op_a_i,
  input  logic [fp32a_pkg::WordW-1:0] op_b_i,
  output fp32a_pkg::align_t           res_o
);
  import fp32a_pkg::*;

  fp32_t            a, b, big, lit;
  logic             nan_a, nan_b, inf_a, inf_b, swap;
  logic [ExpW-1:0]  eb, el, d;
  logic [MantW-1:0] mb, ml, ms, lost_mask;
  logic             sticky;

  always_comb begin
    a = op_a_i;
    b = op_b_i;
    nan_a = (a.exp == ExpMax) && (a.frac != '0);
    nan_b = (b.exp == ExpMax) && (b.frac != '0);
    inf_a = (a.exp == ExpMax) && (a.frac == '0);
    inf_b = (b.exp == ExpMax) && (b.frac == '0);
    swap  = op_a_i[WordW-2:0] < op_b_i[WordW-2:0];
    big   = swap ? b : a;
    lit   = swap ? a : b;
    eb = (big.exp == '0) ? 8'd1 : big.exp;
    el = (lit.exp == '0) ? 8'd1 : lit.exp;
    mb = {(big.exp != '0), big.frac, 3'b000};
    ml = {(lit.exp != '0), lit.frac, 3'b000};
    d  = eb - el;
    lost_mask = '0;
    sticky    = 1'b0;
    if (d >= 8'd27) begin
      ms = {{(MantW-1){1'b0}}, (ml != '0)};
    end else begin
      lost_mask = ~({MantW{1'b1}} << d[4:0]);
      sticky    = (ml & lost_mask) != '0;
      ms        = (ml >> d[4:0]) | {{(MantW-1){1'b0}}, sticky};
    end
    res_o.special      = 1'b1;
    res_o.special_bits = QnanBits;
    if (nan_a || nan_b) begin
      res_o.special_bits = QnanBits;
    end else if (inf_a && inf_b) begin
      res_o.special_bits = (a.sign == b.sign) ? op_a_i : QnanBits;
    end else if (inf_a) begin
      res_o.special_bits = op_a_i;
    end else if (inf_b) begin
      res_o.special_bits = op_b_i;
    end else begin
      res_o.special = 1'b0;
    end
    res_o.sign      = big.sign;
    res_o.zero_sign = a.sign & b.sign;
    res_o.exp       = {1'b0, eb};
    if (a.sign == b.sign) res_o.mant = {1'b0, mb} + {1'b0, ms};
    else                  res_o.mant = {1'b0, mb} - {1'b0, ms};
  end

endmodule

// File: sv/fp32a_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32a_norm
// Normalize, round to nearest even and pack the binary32 result.
// ----------------------------------------------------------------------------
module fp32a_norm (
  input  fp32a_pkg::align_t           al_i,
  output logic [fp32a_pkg::WordW-1:0] sum_o
);
  import fp32a_pkg::*;

  logic [MantW:0]   m;
  logic [MantW-1:0] mn;
  logic [ExpW+1:0]  e;
  logic [4:0]       lz, sh;
  logic [2:0]       g;
  logic [24:0]      r;
  logic             up;

  always_comb begin
    m = al_i.mant;
    e = {1'b0, al_i.exp};
    if (m[MantW]) begin
      m = {1'b0, m[MantW:2], m[1] | m[0]};
      e = e + 10'd1;
    end
    mn = m[MantW-1:0];
    lz = 5'd26;
    for (int i = 0; i < 27; i++) begin
      if (mn[i]) lz = 5'(26 - i);
    end
    if ({5'd0, lz} < e - 10'd1) sh = lz;
    else                        sh = 5'(e - 10'd1);
    mn = mn << sh;
    e  = e - {5'd0, sh};
    g  = mn[2:0];
    up = (g > 3'd4) || ((g == 3'd4) && mn[3]);
    r  = {1'b0, mn[26:3]} + {24'd0, up};
    if (r[24]) begin
      r = r >> 1;
      e = e + 10'd1;
    end
    if (al_i.special) begin
      sum_o = al_i.special_bits;
    end else if (m == '0) begin
      sum_o = {al_i.zero_sign, 31'd0};
    end else if (e >= {2'b00, ExpMax}) begin
      sum_o = {al_i.sign, ExpMax, 23'd0};
    end else begin
      sum_o = {al_i.sign, (r[23] ? e[ExpW-1:0] : 8'd0), r[22:0]};
    end
  end

endmodule

// File: sv/fp32_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_adder
// IEEE 754 binary32 adder, round to nearest even, canonical quiet NaN.
// start passes the operand register, then the result register, to done_o.
// Throughput: one transaction per cycle; busy is always low.
// Reset clears the valid pipeline; done_o is low after reset.
// The receiver cannot stall; done_o flags each result for one cycle.
// ----------------------------------------------------------------------------
module fp32_adder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [fp32a_pkg::WordW-1:0] op_a_i,
  input  logic [fp32a_pkg::WordW-1:0] op_b_i,
  output logic                        done_o,
  output logic [fp32a_pkg::WordW-1:0] sum_bits_o
);
  import fp32a_pkg::*;

  logic [WordW-1:0] a_q, b_q, sum_d, sum_q;
  logic             v_q, done_q;
  align_t           al;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v_q    <= start;
      done_q <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q <= op_a_i;
      b_q <= op_b_i;
    end
    if (v_q) sum_q <= sum_d;
  end

  fp32a_align u_align (.op_a_i(a_q), .op_b_i(b_q), .res_o(al));
  fp32a_norm  u_norm  (.al_i(al), .sum_o(sum_d));

  assign done_o     = done_q;
  assign sum_bits_o = sum_q;

endmodule

// File: sv/fp32a_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32a_checker
// Port-level checks for the binary32 adder.
// ----------------------------------------------------------------------------
module fp32a_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [fp32a_pkg::WordW-1:0] sum_bits_o
);
  import fp32a_pkg::*;

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##2 done_o) else $error("missing result");
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2)) else $error("spurious result");
  a_nan_canon : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && sum_bits_o[30:23] == ExpMax && sum_bits_o[22:0] != '0)
      |-> sum_bits_o == QnanBits) else $error("non-canonical NaN");

endmodule

bind fp32_adder fp32a_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .sum_bits_o(sum_bits_o)
);
